### hdl/bpa_pkg.sv
// Shared types and constants for the bitmap page allocator.
// No dependencies; imported by every module of the block.
package bpa_pkg;

    localparam int MAX_BITMAP_BYTES = 128;

    localparam int ADDR_W     = 32;
    localparam int PS_W       = 17;
    localparam int DVS_W      = PS_W + 3;                  // page_size * 8
    localparam int IX_W       = (MAX_BITMAP_BYTES > 1) ? $clog2(MAX_BITMAP_BYTES) : 1;
    localparam int BIU_W      = $clog2(MAX_BITMAP_BYTES + 1);
    localparam int PG_W       = IX_W + 3;
    localparam int PROD_W     = PG_W + PS_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [7:0] FULL_BYTE = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_END   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE    = 2'd2;

    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    localparam logic [PS_W-1:0] PAGE_SIZE_RESET = 17'd4096;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_OUTSIDE  = 2'd2
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic    take_in;
        logic    scan_clr;
        logic    scan_rd;
        logic    found;
        logic    mul;
        logic    add;
        logic    div_cfg;
        logic    div_rel;
        logic    biu_zero;
        logic    biu_load;
        logic    rel_rd;
        logic    rel_wr;
        logic    load_out;
        t_status out_status;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic cfg_wr;
        logic ps_zero;
        logic reversed;
        logic rel_bad;
        logic rel_oob;
        logic ix_end;
        logic rd_vld;
        logic rd_full;
        logic div_done;
        logic out_busy;
    } t_sts;

endpackage

### hdl/bpa_divider.sv
// Restoring divider, one quotient bit per cycle.
// Depends on bpa_pkg for widths.
module bpa_divider
    import bpa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ADDR_W-1:0] i_dividend,
    input  logic [DVS_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [ADDR_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(ADDR_W + 1);

    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;
    logic [ADDR_W-1:0] r_q;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [DVS_W:0]    w_sh;
    logic [DVS_W:0]    w_diff;
    logic              w_ge;

    assign w_sh   = {r_rem, r_q[ADDR_W-1]};
    assign w_ge   = (w_sh >= {1'b0, r_dvs});
    assign w_diff = w_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CNT_W'(ADDR_W);
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_q   <= {r_q[ADDR_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_sh[DVS_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

### hdl/bpa_datapath.sv
// Datapath: config registers, bitmap store, scan index, multiply-add, output register.
// Depends on bpa_pkg and bpa_divider.
module bpa_datapath
    import bpa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_func,
    input  logic [ADDR_W-1:0]     i_release_address,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [ADDR_W-1:0]     o_page_address,
    output logic [1:0]            o_status,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts
);

    logic [ADDR_W-1:0] r_start;
    logic [ADDR_W-1:0] r_end;
    logic [PS_W-1:0]   r_page_size;
    logic [BIU_W-1:0]  r_biu;
    logic              r_func;
    logic [ADDR_W-1:0] r_addr;
    logic [BIU_W-1:0]  r_ix;
    logic              r_rd_vld;
    logic [IX_W-1:0]   r_rd_ix;
    logic [7:0]        r_rd_data;
    logic              r_rd_vbit;
    logic [PG_W-1:0]   r_page;
    logic [PROD_W-1:0] r_prod;
    logic [ADDR_W-1:0] r_res_addr;
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_out_addr;
    t_status           r_out_status;

    logic [7:0]                  mem [MAX_BITMAP_BYTES];
    logic [MAX_BITMAP_BYTES-1:0] r_vbits;

    logic              w_cfg_wr;
    logic [7:0]        w_rd_byte;
    logic [2:0]        w_low_bit;
    logic [IX_W-1:0]   w_rd_addr;
    logic              w_rd_en;
    logic              w_wr_en;
    logic [7:0]        w_wr_data;
    logic              w_div_start;
    logic [ADDR_W-1:0] w_dividend;
    logic [DVS_W-1:0]  w_divisor;
    logic              w_div_done;
    logic [ADDR_W-1:0] w_q;

    assign w_cfg_wr = i_cfg_we && ((i_cfg_idx == CFG_REGION_START) ||
                                   (i_cfg_idx == CFG_REGION_END) ||
                                   (i_cfg_idx == CFG_PAGE_SIZE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start     <= '0;
            r_end       <= '0;
            r_page_size <= PAGE_SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_REGION_START: r_start     <= i_cfg_data[ADDR_W-1:0];
                CFG_REGION_END:   r_end       <= i_cfg_data[ADDR_W-1:0];
                CFG_PAGE_SIZE:    r_page_size <= i_cfg_data[PS_W-1:0];
                default: ;
            endcase
        end
    end

    // pages in use, in bytes of bitmap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_biu <= '0;
        end else if (w_cfg_wr || i_cmd.biu_zero) begin
            r_biu <= '0;
        end else if (i_cmd.biu_load) begin
            r_biu <= (w_q > ADDR_W'(MAX_BITMAP_BYTES)) ? BIU_W'(MAX_BITMAP_BYTES)
                                                      : w_q[BIU_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_func <= i_func;
            r_addr <= i_release_address;
        end
    end

    // shared divider: region size on configure, page number on release
    assign w_div_start = i_cmd.div_cfg || i_cmd.div_rel;
    assign w_dividend  = i_cmd.div_cfg ? (r_end - r_start) : (r_addr - r_start);
    assign w_divisor   = i_cmd.div_cfg ? {r_page_size, 3'b000} : DVS_W'(r_page_size);

    bpa_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_q)
    );

    // scan index and read pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ix     <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_rd;
            if (i_cmd.scan_clr) begin
                r_ix <= '0;
            end else if (i_cmd.scan_rd) begin
                r_ix <= r_ix + 1'b1;
            end
        end
    end

    assign w_rd_en   = i_cmd.scan_rd || i_cmd.rel_rd;
    assign w_rd_addr = i_cmd.rel_rd ? w_q[IX_W+2:3] : r_ix[IX_W-1:0];
    assign w_rd_byte = r_rd_vbit ? r_rd_data : 8'h00;

    always_comb begin
        w_low_bit = 3'd0;
        for (int b = 7; b >= 0; b--) begin
            if (!w_rd_byte[b]) begin
                w_low_bit = 3'(b);
            end
        end
    end

    assign w_wr_en   = i_cmd.found || i_cmd.rel_wr;
    assign w_wr_data = i_cmd.found ? (w_rd_byte | (8'h01 << w_low_bit))
                                   : (w_rd_byte & ~(8'h01 << w_q[2:0]));

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= mem[w_rd_addr];
            r_rd_ix   <= w_rd_addr;
        end
        if (w_wr_en) begin
            mem[r_rd_ix] <= w_wr_data;
        end
    end

    // per-byte valid: an unwritten byte reads as all clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vbits   <= '0;
            r_rd_vbit <= 1'b0;
        end else begin
            if (w_rd_en) begin
                r_rd_vbit <= r_vbits[w_rd_addr];
            end
            if (w_cfg_wr) begin
                r_vbits <= '0;
            end else if (w_wr_en) begin
                r_vbits[r_rd_ix] <= 1'b1;
            end
        end
    end

    // page address = start + page * page_size
    always_ff @(posedge i_clk) begin
        if (i_cmd.found) begin
            r_page <= {r_rd_ix, w_low_bit};
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_page) * PROD_W'(r_page_size);
        end
        if (i_cmd.add) begin
            r_res_addr <= ADDR_W'(r_prod) + r_start;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= i_cmd.out_status;
            r_out_addr   <= (r_func == FUNC_ALLOC && i_cmd.out_status == ST_OK) ?
                            r_res_addr : '0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_page_address = r_out_addr;
    assign o_status       = r_out_status;

    assign o_sts.cfg_wr   = w_cfg_wr;
    assign o_sts.ps_zero  = (r_page_size == '0);
    assign o_sts.reversed = (r_end < r_start);
    assign o_sts.rel_bad  = (r_page_size == '0) || (r_addr > r_end) || (r_addr < r_start);
    assign o_sts.rel_oob  = (w_q[ADDR_W-1:3] >= (ADDR_W-3)'(r_biu));
    assign o_sts.ix_end   = (r_ix >= r_biu);
    assign o_sts.rd_vld   = r_rd_vld;
    assign o_sts.rd_full  = (w_rd_byte == FULL_BYTE);
    assign o_sts.div_done = w_div_done;
    assign o_sts.out_busy = r_out_valid && !i_out_ready;

endmodule

### hdl/bpa_ctrl.sv
// Controller FSM: sequences configure, allocate scan and release steps.
// Depends on bpa_pkg for command and status structs.
module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_func,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_C_CHK,
        S_C_DIV,
        S_SCAN,
        S_A_MUL,
        S_A_ADD,
        S_R_CHK,
        S_R_DIV,
        S_R_IDX,
        S_R_WR,
        S_DONE
    } t_state;

    t_state  r_state, n_state;
    t_status r_status, n_status;
    t_cmd    w_cmd;

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        w_cmd    = '0;
        w_cmd.out_status = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.take_in = 1'b1;
                    if (i_func == FUNC_ALLOC) begin
                        w_cmd.scan_clr = 1'b1;
                        n_state        = S_SCAN;
                    end else begin
                        n_state = S_R_CHK;
                    end
                end
            end
            S_C_CHK: begin
                if (i_sts.ps_zero || i_sts.reversed) begin
                    w_cmd.biu_zero = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    w_cmd.div_cfg = 1'b1;
                    n_state       = S_C_DIV;
                end
            end
            S_C_DIV: begin
                if (i_sts.div_done) begin
                    w_cmd.biu_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_SCAN: begin
                // one byte read per cycle, checked the cycle after
                priority if (i_sts.rd_vld && !i_sts.rd_full) begin
                    w_cmd.found = 1'b1;
                    n_state     = S_A_MUL;
                end else if (!i_sts.ix_end) begin
                    w_cmd.scan_rd = 1'b1;
                end else if (!i_sts.rd_vld) begin
                    n_status = ST_NO_SPACE;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_A_MUL: begin
                w_cmd.mul = 1'b1;
                n_state   = S_A_ADD;
            end
            S_A_ADD: begin
                w_cmd.add = 1'b1;
                n_status  = ST_OK;
                n_state   = S_DONE;
            end
            S_R_CHK: begin
                if (i_sts.rel_bad) begin
                    n_status = ST_OUTSIDE;
                    n_state  = S_DONE;
                end else begin
                    w_cmd.div_rel = 1'b1;
                    n_state       = S_R_DIV;
                end
            end
            S_R_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_R_IDX;
                end
            end
            S_R_IDX: begin
                if (i_sts.rel_oob) begin
                    n_status = ST_OUTSIDE;
                    n_state  = S_DONE;
                end else begin
                    w_cmd.rel_rd = 1'b1;
                    n_state      = S_R_WR;
                end
            end
            S_R_WR: begin
                w_cmd.rel_wr = 1'b1;
                n_status     = ST_OK;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    w_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // a register write restarts the region setup
        if (i_sts.cfg_wr) begin
            w_cmd   = '0;
            w_cmd.out_status = r_status;
            n_state = S_C_CHK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = w_cmd;

endmodule

### hdl/bitmap_page_allocator.sv
// Bitmap first-fit page allocator, top level.
// Depends on bpa_pkg, bpa_ctrl, bpa_datapath (and bpa_divider below it).
//
// Usage:
//  - Config port: i_cfg_we/i_cfg_idx/i_cfg_data write region_start (0),
//    region_end (1) or page_size (2). Any such write clears the bitmap
//    and recomputes the bytes in use with the shared 32-step divider,
//    during which o_in_ready stays low. Index 3 is ignored.
//  - Input channel (i_in_valid/o_in_ready): one beat per request, i_func
//    0 allocates, 1 releases i_release_address.
//  - Output channel (o_out_valid/i_out_ready): one beat per request,
//    o_page_address and o_status (0 ok, 1 no free page, 2 outside region).
//  - Allocate: bitmap bytes are read one per cycle from the store, scanning
//    up to the bytes in use (at most MAX_BITMAP_BYTES); a multiply and an
//    add stage then form the address.
//  - Release: range check, then the 32-step divider gives the page number,
//    then a check against the bytes in use and a one-byte read-modify-write.
//  - One request is worked on at a time; the next one is taken while a
//    result still waits in the output register, and a stalled receiver
//    only holds the controller in its final step.
//  - Reset: bitmap empty (per-byte valid flags cleared at once, no clearing
//    pass), region 0..0, page size 4096, no bytes in use.
module bitmap_page_allocator
    import bpa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_func,
    input  logic [ADDR_W-1:0]     i_release_address,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [ADDR_W-1:0]     o_page_address,
    output logic [1:0]            o_status
);

    t_cmd w_cmd;
    t_sts w_sts;

    bpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    bpa_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_func            (i_func),
        .i_release_address (i_release_address),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_page_address    (o_page_address),
        .o_status          (o_status),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts)
    );

endmodule
